>>> sv/hmq_pkg.sv
// hmq_pkg: shared types and constants of the quadratic-probe hash multiset.
// No dependencies; imported by hmq_hash and hash_multiset_quadratic_probe.
`timescale 1ns / 1ps
`default_nettype none

package hmq_pkg;

   localparam int KEY_W        = 32;
   localparam int CMD_W        = 2;
   localparam int STAT_W       = 2;
   localparam int COUNT_W      = 16;
   localparam int TOTAL_W      = 24;
   localparam int SINGLE_OUT_W = 7;
   localparam int MARK_W       = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   localparam logic [STAT_W-1:0] RSP_OK      = 2'd0;
   localparam logic [STAT_W-1:0] RSP_ABSENT  = 2'd1;
   localparam logic [STAT_W-1:0] RSP_FULL    = 2'd2;

   localparam logic [MARK_W-1:0] SLOT_EMPTY   = 2'd0;
   localparam logic [MARK_W-1:0] SLOT_USED    = 2'd1;
   localparam logic [MARK_W-1:0] SLOT_DELETED = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFF_FFFF;

   typedef struct packed {
      logic [MARK_W-1:0]  mark;
      logic [COUNT_W-1:0] count;
      logic [KEY_W-1:0]   key;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

endpackage

`default_nettype wire

>>> sv/hmq_ram.sv
// hmq_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/hmq_hash.sv
// hmq_hash: |key| mod TABLE_SIZE by reciprocal multiplication, with a registered result.
// Depends on hmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hmq_hash #(
   parameter int TABLE_SIZE = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                load,
   input  wire logic signed [hmq_pkg::KEY_W-1:0]    key,
   output logic                                     done,
   output logic             [$clog2(TABLE_SIZE)-1:0] rem
);

   import hmq_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_SIZE);
   localparam int SHIFT   = KEY_W + IDX_W;
   localparam int RECIP_W = KEY_W + 1;
   localparam int PROD_W  = KEY_W + RECIP_W;
   localparam int QUOT_W  = PROD_W - SHIFT;
   localparam logic [63:0]        RECIP_FULL = ((64'd1 << SHIFT) / 64'(TABLE_SIZE)) + 64'd1;
   localparam logic [RECIP_W-1:0] RECIP      = RECIP_FULL[RECIP_W-1:0];
   localparam logic [KEY_W-1:0]   SIZE_K     = KEY_W'(TABLE_SIZE);

   logic [KEY_W-1:0]  key_u;
   logic [KEY_W-1:0]  mag;
   logic [PROD_W-1:0] prod;
   logic [KEY_W-1:0]  diff;
   logic [KEY_W-1:0]  mag_ff, mag_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic              mul_ff, mul_in;
   logic              sub_ff, sub_in;
   logic              done_ff, done_in;

   assign key_u = $unsigned(key);
   assign mag   = key_u[KEY_W-1] ? (~key_u + KEY_W'(1)) : key_u;
   assign prod  = {{RECIP_W{1'b0}}, mag_ff} * {{KEY_W{1'b0}}, RECIP};
   assign diff  = mag_ff - KEY_W'(quot_ff) * SIZE_K;

   always_comb begin
      mag_in  = mag_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      mul_in  = load;
      sub_in  = mul_ff;
      done_in = sub_ff;
      if (load) begin
         mag_in = mag;
      end
      if (mul_ff) begin
         quot_in = prod[PROD_W-1:SHIFT];
      end
      if (sub_ff) begin
         rem_in = diff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         sub_ff  <= sub_in;
         done_ff <= done_in;
      end
      mag_ff  <= mag_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

>>> sv/hash_multiset_quadratic_probe.sv
// hash_multiset_quadratic_probe: top level, command sequencer, probe walk and update.
// Depends on hmq_pkg, hmq_ram, hmq_hash.
//
//   channel   direction  ports                                           handshake
//   request   in         req_cmd, req_key                                start & !busy
//   response  out        rsp_status, rsp_occurrences,                    rsp_strobe
//                        rsp_total_items, rsp_singleton_keys
//
// One word runs from accept to response strobe through |key| mod TABLE_SIZE by
// reciprocal multiply, loading the first probe position, the slot RAM read, one
// read per probe for P probes (1 .. TABLE_SIZE), and the update. busy drops with
// the strobe, so no new word is taken before the response to the last one.
// After reset a clearing pass marks all TABLE_SIZE slots empty, one per cycle,
// with busy high. The response strobe lasts one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module hash_multiset_quadratic_probe #(
   parameter int TABLE_SIZE = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic        [hmq_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic signed [hmq_pkg::KEY_W-1:0]    req_key,
   output logic                                     rsp_strobe,
   output logic        [hmq_pkg::STAT_W-1:0]        rsp_status,
   output logic        [hmq_pkg::COUNT_W-1:0]       rsp_occurrences,
   output logic        [hmq_pkg::TOTAL_W-1:0]       rsp_total_items,
   output logic        [hmq_pkg::SINGLE_OUT_W-1:0]  rsp_singleton_keys
);

   import hmq_pkg::*;

   localparam int IDX_W    = $clog2(TABLE_SIZE);
   localparam int SINGLE_W = $clog2(TABLE_SIZE + 1);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TABLE_SIZE - 1);
   localparam logic [IDX_W-1:0] THREE_MOD = IDX_W'(3 % TABLE_SIZE);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_HASH   = 6'b000100,
      ST_ADDR   = 6'b001000,
      ST_PROBE  = 6'b010000,
      ST_UPDATE = 6'b100000
   } state_type;

   function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (IDX_W+1)'(TABLE_SIZE)) begin
         s = s - (IDX_W+1)'(TABLE_SIZE);
      end
      return s[IDX_W-1:0];
   endfunction

   state_type                state_ff, state_in;
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic signed [KEY_W-1:0]  key_ff, key_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic [IDX_W-1:0]         dmod_ff, dmod_in;
   logic [IDX_W-1:0]         step_ff, step_in;
   logic [IDX_W-1:0]         del_ff, del_in;
   logic                     del_valid_ff, del_valid_in;
   logic                     found_ff, found_in;
   logic                     free_valid_ff, free_valid_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic [COUNT_W-1:0]       hit_count_ff, hit_count_in;
   logic [TOTAL_W-1:0]       total_ff, total_in;
   logic [SINGLE_W-1:0]      single_ff, single_in;
   logic [IDX_W-1:0]         clr_ff, clr_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]       rsp_occ_ff, rsp_occ_in;

   logic                     hash_load;
   logic                     hash_done;
   logic [IDX_W-1:0]         hash_rem;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   slot_type                 wr_slot;
   logic [IDX_W-1:0]         rd_addr;
   logic [SLOT_W-1:0]        rd_data;
   slot_type                 rd_slot;
   logic [IDX_W-1:0]         next_pos;
   logic [IDX_W-1:0]         next_dmod;
   logic                     is_used;
   logic                     is_del;
   logic                     is_hit;
   logic [31:0]              single_wide;

   hmq_hash #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .load  (hash_load),
      .key   (req_key),
      .done  (hash_done),
      .rem   (hash_rem)
   );

   hmq_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_SIZE)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_slot   = slot_type'(rd_data);
   assign is_used   = (rd_slot.mark == SLOT_USED);
   assign is_del    = (rd_slot.mark == SLOT_DELETED);
   assign is_hit    = is_used && (rd_slot.key == $unsigned(key_ff));
   assign next_pos  = mod_add(pos_ff, dmod_ff);
   assign next_dmod = step_ff[0] ? mod_add(dmod_ff, IDX_LAST) : mod_add(dmod_ff, THREE_MOD);

   always_comb begin
      logic [SINGLE_W-1:0] s_tmp;
      logic [COUNT_W-1:0]  c_tmp;
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      dmod_in       = dmod_ff;
      step_in       = step_ff;
      del_in        = del_ff;
      del_valid_in  = del_valid_ff;
      found_in      = found_ff;
      free_valid_in = free_valid_ff;
      slot_in       = slot_ff;
      hit_count_in  = hit_count_ff;
      total_in      = total_ff;
      single_in     = single_ff;
      clr_in        = clr_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      hash_load     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = slot_ff;
      wr_slot       = '{mark: SLOT_USED, count: hit_count_ff, key: $unsigned(key_ff)};
      rd_addr       = pos_ff;
      s_tmp         = single_ff;
      c_tmp         = hit_count_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en        = 1'b1;
            wr_addr      = clr_ff;
            wr_slot.mark = SLOT_EMPTY;
            clr_in       = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd_in    = req_cmd;
               key_in    = req_key;
               state_in  = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               pos_in       = hash_rem;
               dmod_in      = '0;
               step_in      = '0;
               del_valid_in = 1'b0;
               state_in     = ST_ADDR;
            end
         end
         ST_ADDR: begin
            rd_addr  = pos_ff;
            state_in = ST_PROBE;
         end
         ST_PROBE: begin
            if (is_hit) begin
               found_in     = 1'b1;
               slot_in      = pos_ff;
               hit_count_in = rd_slot.count;
               state_in     = ST_UPDATE;
            end else if (!is_used && !is_del) begin
               found_in      = 1'b0;
               free_valid_in = 1'b1;
               slot_in       = del_valid_ff ? del_ff : pos_ff;
               state_in      = ST_UPDATE;
            end else begin
               if (is_del && !del_valid_ff) begin
                  del_in       = pos_ff;
                  del_valid_in = 1'b1;
               end
               if (step_ff == IDX_LAST) begin
                  found_in      = 1'b0;
                  free_valid_in = del_valid_ff || is_del;
                  slot_in       = del_valid_ff ? del_ff : pos_ff;
                  state_in      = ST_UPDATE;
               end else begin
                  pos_in  = next_pos;
                  dmod_in = next_dmod;
                  step_in = step_ff + IDX_W'(1);
                  rd_addr = next_pos;
               end
            end
         end
         ST_UPDATE: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = RSP_OK;
            rsp_occ_in    = '0;
            state_in      = ST_IDLE;
            case (cmd_ff)
               CMD_INSERT: begin
                  if (found_ff) begin
                     if (hit_count_ff != COUNT_MAX) begin
                        if (hit_count_ff == COUNT_W'(1) && single_ff != '0) begin
                           s_tmp = single_ff - SINGLE_W'(1);
                        end
                        c_tmp         = hit_count_ff + COUNT_W'(1);
                        wr_en         = 1'b1;
                        wr_slot.count = c_tmp;
                        single_in     = s_tmp;
                        if (total_ff != TOTAL_MAX) begin
                           total_in = total_ff + TOTAL_W'(1);
                        end
                     end
                     rsp_occ_in = c_tmp;
                  end else if (free_valid_ff) begin
                     wr_en         = 1'b1;
                     wr_slot.count = COUNT_W'(1);
                     single_in     = single_ff + SINGLE_W'(1);
                     if (total_ff != TOTAL_MAX) begin
                        total_in = total_ff + TOTAL_W'(1);
                     end
                     rsp_occ_in = COUNT_W'(1);
                  end else begin
                     rsp_status_in = RSP_FULL;
                  end
               end
               CMD_REMOVE: begin
                  if (found_ff) begin
                     if (hit_count_ff == COUNT_W'(1) && single_ff != '0) begin
                        s_tmp = single_ff - SINGLE_W'(1);
                     end
                     if (hit_count_ff != '0) begin
                        c_tmp = hit_count_ff - COUNT_W'(1);
                     end
                     if (c_tmp == COUNT_W'(1)) begin
                        s_tmp = s_tmp + SINGLE_W'(1);
                     end
                     single_in     = s_tmp;
                     wr_en         = 1'b1;
                     wr_slot.count = c_tmp;
                     wr_slot.mark  = (c_tmp == '0) ? SLOT_DELETED : SLOT_USED;
                     if (total_ff != '0) begin
                        total_in = total_ff - TOTAL_W'(1);
                     end
                     rsp_occ_in = c_tmp;
                  end else begin
                     rsp_status_in = RSP_ABSENT;
                  end
               end
               default: begin
                  if (found_ff) begin
                     rsp_occ_in = hit_count_ff;
                  end else begin
                     rsp_status_in = RSP_ABSENT;
                  end
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (state_ff == ST_IDLE && start) begin
         hash_load = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         total_ff      <= '0;
         single_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
         found_ff      <= 1'b0;
         free_valid_ff <= 1'b0;
         del_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         total_ff      <= total_in;
         single_ff     <= single_in;
         rsp_strobe_ff <= rsp_strobe_in;
         found_ff      <= found_in;
         free_valid_ff <= free_valid_in;
         del_valid_ff  <= del_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      dmod_ff       <= dmod_in;
      step_ff       <= step_in;
      del_ff        <= del_in;
      slot_ff       <= slot_in;
      hit_count_ff  <= hit_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign single_wide        = 32'(single_ff);
   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_occurrences    = rsp_occ_ff;
   assign rsp_total_items    = total_ff;
   assign rsp_singleton_keys = single_wide[SINGLE_OUT_W-1:0];

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("response strobe held for more than one cycle");

   a_accept_hash: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start) |=> (state_ff == ST_HASH))
      else $error("accepted word did not start the hash unit");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (32'(pos_ff) < TABLE_SIZE))
      else $error("probe position outside the table");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff == RSP_FULL) |-> (rsp_occ_ff == '0))
      else $error("table-full response with nonzero count");

   a_strobe_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_UPDATE))
      else $error("response strobe without an update cycle");

endmodule

`default_nettype wire
